// ===== rtl/tdi_pkg.sv =====
// Shared types, constants and helpers of the trapezoid double integrator.
// No dependencies; every other file of the block imports this package.
package tdi_pkg;

   localparam int ACCEL_BITS_DEFAULT = 16;

   // configuration port
   localparam int CFG_W       = 16;
   localparam int CSR_INDEX_W = 1;
   localparam logic [CFG_W-1:0] TIME_STEP_RESET    = 16'd10486;
   localparam logic [CFG_W-1:0] BLOCK_LENGTH_RESET = 16'd100;

   // accumulator and product widths
   localparam int VEL_W     = 48;
   localparam int POS_W     = 48;
   localparam int VSUM_W    = VEL_W + 1;
   localparam int LO_SPLIT  = 24;
   localparam int HI_W      = VSUM_W - LO_SPLIT;
   localparam int FULL_W    = VSUM_W + CFG_W + 1;
   localparam int POS_SHIFT = 31;
   localparam int DP_W      = FULL_W - POS_SHIFT;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TIME_STEP    = 1'd0,
      CSR_BLOCK_LENGTH = 1'd1
   } tdi_csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DV_MUL,
      ST_VEL,
      ST_SUM,
      ST_LO_MUL,
      ST_HI_MUL,
      ST_COMBINE,
      ST_POS
   } tdi_state_type;

   typedef enum logic [1:0] {
      MUL_ACCEL_SUM,
      MUL_VSUM_LO,
      MUL_VSUM_HI
   } tdi_mul_sel_type;

   typedef struct packed {
      logic            capture;
      tdi_mul_sel_type mul_sel;
      logic            load_prod;
      logic            load_lo;
      logic            load_vnew;
      logic            load_vsum;
      logic            load_dp;
      logic            commit;
   } tdi_cmd_type;

   typedef struct packed {
      logic have_prev;
      logic rsp_free;
   } tdi_status_type;

   // clamp to the 48-bit signed range
   function automatic logic signed [VEL_W-1:0] sat48(input logic signed [63:0] x);
      logic signed [63:0] hi_lim;
      logic signed [63:0] lo_lim;
      hi_lim = 64'sh0000_7FFF_FFFF_FFFF;
      lo_lim = -hi_lim - 64'sd1;
      if (x > hi_lim) begin
         sat48 = hi_lim[VEL_W-1:0];
      end else if (x < lo_lim) begin
         sat48 = lo_lim[VEL_W-1:0];
      end else begin
         sat48 = x[VEL_W-1:0];
      end
   endfunction

endpackage

// ===== rtl/tdi_ifs.sv =====
// Valid/ready channel interfaces for sample items and result items.
// Depends on tdi_pkg for widths.
interface tdi_req_if #(parameter int ACCEL_BITS = tdi_pkg::ACCEL_BITS_DEFAULT);
   logic                         valid;
   logic                         ready;
   logic signed [ACCEL_BITS-1:0] accel_z;

   modport source (output valid, output accel_z, input ready);
   modport sink   (input valid, input accel_z, output ready);
endinterface

interface tdi_rsp_if #(parameter int ACCEL_BITS = tdi_pkg::ACCEL_BITS_DEFAULT);
   import tdi_pkg::*;
   logic                         valid;
   logic                         ready;
   logic signed [VEL_W-1:0]      velocity_z;
   logic signed [POS_W-1:0]      position_z;
   logic signed [ACCEL_BITS-1:0] peak_accel;
   logic                         block_done;

   modport source (output valid, output velocity_z, output position_z,
                   output peak_accel, output block_done, input ready);
   modport sink   (input valid, input velocity_z, input position_z,
                   input peak_accel, input block_done, output ready);
endinterface

// ===== rtl/tdi_ctrl.sv =====
// Sequencer of the trapezoid double integrator: steps one item through
// the shared multiplier and the accumulators. Depends on tdi_pkg.
module tdi_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  tdi_pkg::tdi_status_type status,
   output tdi_pkg::tdi_cmd_type    cmd
);
   import tdi_pkg::*;

   tdi_state_type state_ff;
   tdi_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && status.have_prev) begin
               state_in = ST_DV_MUL;
            end
         end
         ST_DV_MUL:  state_in = ST_VEL;
         ST_VEL:     state_in = ST_SUM;
         ST_SUM:     state_in = ST_LO_MUL;
         ST_LO_MUL:  state_in = ST_HI_MUL;
         ST_HI_MUL:  state_in = ST_COMBINE;
         ST_COMBINE: state_in = ST_POS;
         ST_POS: begin
            if (status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      cmd.mul_sel = MUL_ACCEL_SUM;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_DV_MUL: begin
            cmd.mul_sel   = MUL_ACCEL_SUM;
            cmd.load_prod = 1'b1;
         end
         ST_VEL:     cmd.load_vnew = 1'b1;
         ST_SUM:     cmd.load_vsum = 1'b1;
         ST_LO_MUL: begin
            cmd.mul_sel = MUL_VSUM_LO;
            cmd.load_lo = 1'b1;
         end
         ST_HI_MUL: begin
            cmd.mul_sel   = MUL_VSUM_HI;
            cmd.load_prod = 1'b1;
         end
         ST_COMBINE: cmd.load_dp = 1'b1;
         ST_POS:     cmd.commit  = status.rsp_free;
         default: begin
         end
      endcase
   end

endmodule

// ===== rtl/tdi_datapath.sv =====
// Datapath of the trapezoid double integrator: configuration registers,
// shared multiplier, accumulators and result register. Depends on tdi_pkg.
module tdi_datapath #(
   parameter int ACCEL_BITS = tdi_pkg::ACCEL_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [tdi_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [tdi_pkg::CFG_W-1:0]         csr_write_data,
   input  logic signed [ACCEL_BITS-1:0]      accel_z,
   input  tdi_pkg::tdi_cmd_type              cmd,
   output tdi_pkg::tdi_status_type           status,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic signed [tdi_pkg::VEL_W-1:0]  velocity_z,
   output logic signed [tdi_pkg::POS_W-1:0]  position_z,
   output logic signed [ACCEL_BITS-1:0]      peak_accel,
   output logic                              block_done
);
   import tdi_pkg::*;

   localparam int ASUM_W = ACCEL_BITS + 1;
   localparam int MUL_W  = (ASUM_W > HI_W) ? ASUM_W : HI_W;
   localparam int PROD_W = MUL_W + CFG_W + 1;
   localparam int VTRY_W = ((PROD_W > VEL_W) ? PROD_W : VEL_W) + 1;

   // configuration
   logic [CFG_W-1:0] time_step_ff;
   logic [CFG_W-1:0] block_length_ff;

   // control state
   logic             have_prev_ff;
   logic [CFG_W-1:0] count_ff;
   logic             rsp_valid_ff;

   // payload state
   logic signed [ACCEL_BITS-1:0] prev_ff;
   logic signed [ACCEL_BITS-1:0] cur_ff;
   logic signed [ACCEL_BITS-1:0] max_ff;
   logic                         done_ff;
   logic signed [VEL_W-1:0]      vel_ff;
   logic signed [POS_W-1:0]      pos_ff;
   logic signed [PROD_W-1:0]     prod_ff;
   logic signed [PROD_W-1:0]     lo_ff;
   logic signed [VEL_W-1:0]      vnew_ff;
   logic signed [VSUM_W-1:0]     vsum_ff;
   logic signed [DP_W-1:0]       dp_ff;
   logic signed [VEL_W-1:0]      out_vel_ff;
   logic signed [POS_W-1:0]      out_pos_ff;
   logic signed [ACCEL_BITS-1:0] out_peak_ff;
   logic                         out_done_ff;

   // combinational
   logic [CFG_W-1:0]         blen;
   logic [CFG_W:0]           count_inc;
   logic                     done_in;
   logic signed [ASUM_W-1:0] accel_sum;
   logic signed [MUL_W-1:0]  mul_a;
   logic signed [PROD_W-1:0] mul_out;
   logic signed [VTRY_W-1:0] vel_try;
   logic signed [FULL_W-1:0] full_prod;
   logic signed [POS_W-1:0]  pos_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff    <= TIME_STEP_RESET;
         block_length_ff <= BLOCK_LENGTH_RESET;
      end else if (csr_write_enable) begin
         unique case (tdi_csr_type'(csr_index))
            CSR_TIME_STEP:    time_step_ff    <= csr_write_data;
            CSR_BLOCK_LENGTH: block_length_ff <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // block counting; zero length behaves as one
   always_comb begin
      blen      = (block_length_ff == '0) ? CFG_W'(1) : block_length_ff;
      count_inc = (CFG_W + 1)'(count_ff) + (CFG_W + 1)'(1);
      done_in   = count_inc >= (CFG_W + 1)'(blen);
   end

   // shared multiplier
   always_comb begin
      accel_sum = ASUM_W'(prev_ff) + ASUM_W'(cur_ff);
      case (cmd.mul_sel)
         MUL_VSUM_LO: mul_a = MUL_W'($signed({1'b0, vsum_ff[LO_SPLIT-1:0]}));
         MUL_VSUM_HI: mul_a = MUL_W'($signed(vsum_ff[VSUM_W-1:LO_SPLIT]));
         default:     mul_a = MUL_W'(accel_sum);
      endcase
      mul_out = PROD_W'(mul_a) * PROD_W'($signed({1'b0, time_step_ff}));
   end

   always_comb begin
      vel_try   = VTRY_W'(vel_ff) + VTRY_W'(prod_ff >>> 1);
      full_prod = (FULL_W'(prod_ff) <<< LO_SPLIT) + FULL_W'(lo_ff);
      pos_in    = sat48(64'(pos_ff) + 64'(dp_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff <= 1'b0;
         count_ff     <= '0;
         max_ff       <= '0;
         prev_ff      <= '0;
         vel_ff       <= '0;
         pos_ff       <= '0;
      end else begin
         if (cmd.capture) begin
            if (!have_prev_ff || accel_z > max_ff) begin
               max_ff <= accel_z;
            end
            count_ff <= done_in ? '0 : count_inc[CFG_W-1:0];
            if (!have_prev_ff) begin
               prev_ff      <= accel_z;
               have_prev_ff <= 1'b1;
            end
         end
         if (cmd.commit) begin
            vel_ff  <= vnew_ff;
            pos_ff  <= pos_in;
            prev_ff <= cur_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cur_ff  <= accel_z;
         done_ff <= done_in;
      end
      if (cmd.load_prod) begin
         prod_ff <= mul_out;
      end
      if (cmd.load_lo) begin
         lo_ff <= mul_out;
      end
      if (cmd.load_vnew) begin
         vnew_ff <= sat48(64'(vel_try));
      end
      if (cmd.load_vsum) begin
         vsum_ff <= VSUM_W'(vel_ff) + VSUM_W'(vnew_ff);
      end
      if (cmd.load_dp) begin
         dp_ff <= DP_W'(full_prod >>> POS_SHIFT);
      end
      if (cmd.commit) begin
         out_vel_ff  <= vnew_ff;
         out_pos_ff  <= pos_in;
         out_peak_ff <= max_ff;
         out_done_ff <= done_ff;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign status.have_prev = have_prev_ff;
   assign status.rsp_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid  = rsp_valid_ff;
   assign velocity_z = out_vel_ff;
   assign position_z = out_pos_ff;
   assign peak_accel = out_peak_ff;
   assign block_done = out_done_ff;

endmodule

// ===== rtl/trapezoid_double_integrator.sv =====
// Trapezoid-rule double integrator: acceleration items in, velocity and
// position items out. Depends on tdi_pkg, tdi_ifs, tdi_ctrl, tdi_datapath.
//
// Usage:
//  - req_bus carries one signed acceleration sample per item (valid/ready).
//  - rsp_bus carries velocity, position, peak sample and a block-done flag.
//  - csr_* writes time_step (index 0) or block_length (index 1) at any edge
//    with csr_write_enable high; write only while the block is idle.
//  - The first sample after reset primes the previous-sample register and
//    yields no item; the sequencer stays idle and it is counted toward the block.
//  - Every later sample occupies the block until its result is committed, so
//    the next item can be accepted only after that: one accept step, then seven
//    sequencer steps around the one shared multiplier (accel sum, low and
//    high halves of the velocity sum) and the saturating accumulators.
//    The result becomes valid when the last step commits it.
//  - A result waits in an output register; the sequencer holds in its last
//    step while the receiver stalls and a previous result is not taken.
//  - Reset (synchronous, active high) clears the accumulators, peak,
//    block counter and restores time_step = 10486, block_length = 100.
module trapezoid_double_integrator #(
   parameter int ACCEL_BITS = tdi_pkg::ACCEL_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   tdi_req_if.sink                         req_bus,
   tdi_rsp_if.source                       rsp_bus,
   input  logic                            csr_write_enable,
   input  logic [tdi_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tdi_pkg::CFG_W-1:0]       csr_write_data
);
   import tdi_pkg::*;

   tdi_cmd_type    cmd;
   tdi_status_type status;

   // sequencer: decide which datapath step runs each cycle
   tdi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: configuration, multiplier, accumulators, result register
   tdi_datapath #(
      .ACCEL_BITS (ACCEL_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .accel_z          (req_bus.accel_z),
      .cmd              (cmd),
      .status           (status),
      .rsp_ready        (rsp_bus.ready),
      .rsp_valid        (rsp_bus.valid),
      .velocity_z       (rsp_bus.velocity_z),
      .position_z       (rsp_bus.position_z),
      .peak_accel       (rsp_bus.peak_accel),
      .block_done       (rsp_bus.block_done)
   );

`ifndef SYNTHESIS
   // a priming item never produces a result
   assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready && !status.have_prev) |=> !$rose(rsp_bus.valid))
      else $error("priming item produced a result");

   // an integrating item keeps the input closed while it is in flight
   assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready && status.have_prev) |=> !req_bus.ready)
      else $error("input reopened during integration");

   // a new result is loaded only when the output register is free
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_bus.valid || rsp_bus.ready))
      else $error("result overwritten while stalled");

   // capture and commit never coincide
   assert property (@(posedge clock) disable iff (reset)
      !(cmd.capture && cmd.commit))
      else $error("capture and commit in the same cycle");
`endif

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for trapezoid_double_integrator: sample items in, motion items out.
// Depends on tdi_pkg and the tdi_req_if / tdi_rsp_if interfaces of the block.
module testbench;
   import tdi_pkg::*;

   // wide signed type for the integration arithmetic; no step can overflow it
   typedef logic signed [80:0] wide_type;

   typedef struct packed {
      logic signed [VEL_W-1:0] velocity;
      logic signed [POS_W-1:0] position;
      logic signed [15:0]      peak;
      logic                    done;
   } motion_result_type;

   localparam wide_type RAIL_HIGH = 81'sd140737488355327;
   localparam wide_type RAIL_LOW  = -81'sd140737488355328;
   // margin for the block to finish its last sample; the priming one gives no item
   localparam int SETTLE_CYCLES = 12;
   // no correct run goes this long without moving an item on either channel
   localparam int QUIET_LIMIT = 2000;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_SAMPLES = 160;
   localparam int RAMP_UP_SAMPLES = 40;
   localparam int RAMP_DOWN_SAMPLES = 20;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_write_enable;
   tdi_csr_type csr_index;
   logic [CFG_W-1:0] csr_write_data;

   tdi_req_if req_if ();
   tdi_rsp_if rsp_if ();

   trapezoid_double_integrator u_top (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_if),
      .rsp_bus          (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Integrator state as the block should hold it, and its configuration.
   logic [15:0]        step_size;
   logic [15:0]        block_length;
   logic signed [15:0] prev_accel;
   logic               primed;
   logic signed [VEL_W-1:0] vel_acc;
   logic signed [POS_W-1:0] pos_acc;
   logic signed [15:0] peak_seen;
   logic [15:0]        block_count;

   logic signed [15:0] pending_samples[$];
   motion_result_type  expected_motion[$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int mismatches     = 0;
   int samples_taken  = 0;
   int results_seen   = 0;
   int block_marks    = 0;
   int rail_hits      = 0;
   int quiet_cycles   = 0;

   function automatic wide_type clamp_rail(input wide_type x);
      if (x > RAIL_HIGH) begin
         return RAIL_HIGH;
      end else if (x < RAIL_LOW) begin
         return RAIL_LOW;
      end
      return x;
   endfunction

   // Advance the integrator by one accepted sample; queue the item it gives.
   task automatic integrate_sample(input logic signed [15:0] accel);
      wide_type          step_w;
      wide_type          dv;
      wide_type          v_new;
      wide_type          vsum;
      wide_type          p_new;
      logic [16:0]       count_next;
      logic [15:0]       length_eff;
      logic              done;
      motion_result_type res;
      step_w = step_size;
      if (!primed || accel > peak_seen) begin
         peak_seen = accel;
      end
      // a zero block length acts as one
      length_eff = (block_length == 16'd0) ? 16'd1 : block_length;
      count_next = block_count + 17'd1;
      done = (count_next >= length_eff);
      block_count = done ? 16'd0 : count_next[15:0];
      if (!primed) begin
         // first sample only loads the previous-sample register
         prev_accel = accel;
         primed = 1'b1;
      end else begin
         dv = ((wide_type'(prev_accel) + wide_type'(accel)) * step_w) >>> 1;
         v_new = clamp_rail(wide_type'(vel_acc) + dv);
         // position uses the old velocity and the new, clamped one
         vsum = wide_type'(vel_acc) + v_new;
         p_new = clamp_rail(wide_type'(pos_acc) + ((vsum * step_w) >>> 31));
         if (v_new == RAIL_HIGH || v_new == RAIL_LOW ||
             p_new == RAIL_HIGH || p_new == RAIL_LOW) begin
            rail_hits++;
         end
         vel_acc = v_new[VEL_W-1:0];
         pos_acc = p_new[POS_W-1:0];
         prev_accel = accel;
         res.velocity = vel_acc;
         res.position = pos_acc;
         res.peak = peak_seen;
         res.done = done;
         expected_motion.push_back(res);
      end
   endtask

   task automatic report_mismatch(input string field, input logic signed [63:0] want,
                                  input logic signed [63:0] got);
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
      mismatches++;
   endtask

   task automatic check_motion(input logic signed [VEL_W-1:0] velocity,
                               input logic signed [POS_W-1:0] position,
                               input logic signed [15:0] peak, input logic done);
      motion_result_type want;
      if (expected_motion.size() == 0) begin
         $display("%0t: unexpected item: velocity %0d position %0d peak %0d done %0b",
                  $time, velocity, position, peak, done);
         mismatches++;
      end else begin
         want = expected_motion.pop_front();
         if (velocity !== want.velocity) begin
            report_mismatch("velocity_z", want.velocity, velocity);
         end
         if (position !== want.position) begin
            report_mismatch("position_z", want.position, position);
         end
         if (peak !== want.peak) begin
            report_mismatch("peak_accel", want.peak, peak);
         end
         if (done !== want.done) begin
            report_mismatch("block_done", want.done, done);
         end
         if (want.done) begin
            block_marks++;
         end
      end
      results_seen++;
   endtask

   // Driver: predict on acceptance, then offer the next pending sample unless idling.
   // Valid drops only when there is nothing to offer or the sender idles.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            integrate_sample(req_if.accel_z);
            samples_taken++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_if.accel_z <= pending_samples.pop_front();
               req_if.valid <= 1'b1;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each accepted item, then pick the next ready at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            check_motion(rsp_if.velocity_z, rsp_if.position_z, rsp_if.peak_accel,
                         rsp_if.block_done);
         end
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog: end the run when no item moves for too long.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Write one register; only called while the block is idle. Returns at a falling edge.
   task automatic write_register(input tdi_csr_type idx, input logic [15:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_TIME_STEP) begin
         step_size = value;
      end else if (idx == CSR_BLOCK_LENGTH) begin
         block_length = value;
      end
      @(negedge clock);
   endtask

   // Wait until every sample is taken and every item is back, then let the block settle.
   task automatic wait_for_drain();
      do begin
         @(negedge clock);
      end while (pending_samples.size() != 0 || req_if.valid || expected_motion.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_idling(input int mode);
      case (mode)
         0: begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         1: begin
            send_idle_pct = 87;
            recv_stall_pct = 0;
         end
         2: begin
            send_idle_pct = 0;
            recv_stall_pct = 87;
         end
         default: begin
            send_idle_pct = 9;
            recv_stall_pct = 9;
         end
      endcase
   endtask

   // Wide random samples half the time, with extremes, small steps and repeats mixed in.
   function automatic logic signed [15:0] next_sample(input logic signed [15:0] last);
      int walk;
      case ($urandom_range(9))
         0: begin
            case ($urandom_range(3))
               0: return 16'sh8000;
               1: return 16'sh7FFF;
               2: return 16'sd0;
               default: return -16'sd1;
            endcase
         end
         1, 2, 3: begin
            walk = int'(last) + int'($urandom_range(64)) - 32;
            return walk[15:0];
         end
         4: return last;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_step_size();
      case ($urandom_range(9))
         0: return 16'd0;
         1: return 16'hFFFF;
         2: return 16'd1;
         default: return 16'($urandom_range(65535, 1));
      endcase
   endfunction

   function automatic logic [15:0] pick_block_length();
      case ($urandom_range(9))
         0: return 16'd0;
         1: return 16'd1;
         2: return 16'hFFFF;
         default: return 16'($urandom_range(40, 2));
      endcase
   endfunction

   initial begin
      logic signed [15:0] last;
      int phase;
      int n;

      // known values on every input before the first edge
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = CSR_TIME_STEP;
      csr_write_data = '0;
      req_if.valid = 1'b0;
      req_if.accel_z = '0;
      rsp_if.ready = 1'b0;
      step_size = TIME_STEP_RESET;
      block_length = BLOCK_LENGTH_RESET;
      prev_accel = '0;
      primed = 1'b0;
      vel_acc = '0;
      pos_acc = '0;
      peak_seen = '0;
      block_count = '0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset values of both registers; the first item only primes the integrator.
      // Cover both extremes, zero and the values around it.
      pending_samples = '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sd0, -16'sd1, 16'sd1,
                          16'sh8000, 16'sh8000, 16'sd100, -16'sd100};
      wait_for_drain();

      // Longest step, every sample closes a block.
      write_register(CSR_TIME_STEP, 16'hFFFF);
      write_register(CSR_BLOCK_LENGTH, 16'd1);
      pending_samples = '{16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sd12345, -16'sd1};
      wait_for_drain();

      // Zero step: accumulators hold. Zero block length acts as one.
      write_register(CSR_TIME_STEP, 16'd0);
      write_register(CSR_BLOCK_LENGTH, 16'd0);
      pending_samples = '{16'sh8000, 16'sh7FFF, 16'sd5, -16'sd7, 16'sd0};
      wait_for_drain();

      // Shortest step and longest block: the count climbs to eight.
      write_register(CSR_TIME_STEP, 16'd1);
      write_register(CSR_BLOCK_LENGTH, 16'hFFFF);
      pending_samples = '{16'sd1, 16'sd2, 16'sd3, 16'sd4, -16'sd4, -16'sd3, -16'sd2,
                          -16'sd1};
      wait_for_drain();

      // Block length lowered below the running count: the next sample closes a block.
      write_register(CSR_TIME_STEP, 16'd20000);
      write_register(CSR_BLOCK_LENGTH, 16'd3);
      pending_samples = '{16'sh7FFF, 16'sh8000};
      wait_for_drain();

      // Random phases: fresh configuration each time, idling modes in turn.
      last = 16'sd0;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_register(CSR_TIME_STEP, pick_step_size());
         write_register(CSR_BLOCK_LENGTH, pick_block_length());
         set_idling(phase % 4);
         for (n = 0; n < PHASE_SAMPLES; n++) begin
            last = next_sample(last);
            pending_samples.push_back(last);
         end
         wait_for_drain();
      end

      // Push velocity and position hard with full-scale samples at the longest step,
      // then reverse the acceleration and pull velocity back.
      set_idling(0);
      write_register(CSR_TIME_STEP, 16'hFFFF);
      write_register(CSR_BLOCK_LENGTH, 16'd7);
      for (n = 0; n < RAMP_UP_SAMPLES; n++) begin
         pending_samples.push_back(16'sh7FFF);
      end
      for (n = 0; n < RAMP_DOWN_SAMPLES; n++) begin
         pending_samples.push_back(16'sh8000);
      end
      wait_for_drain();

      $display("Covered %0d samples and %0d items (%0d block boundaries, %0d on a rail)",
               samples_taken, results_seen, block_marks, rail_hits);
      $display("Configurations included zero and full-scale steps and block lengths");
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("FAIL");
      end
      $finish;
   end

endmodule
